@@ rtl/core/fct_pkg.sv @@
`timescale 1ns / 1ps

package fct_pkg;

    localparam int ADDR_W  = 32;
    localparam int KEY_W   = ADDR_W + 1;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 64;
    localparam int STAMP_W = 64;

    localparam logic [7:0] LOOPBACK_OCTET = 8'd127;
    localparam logic       DIR_EGRESS     = 1'b1;
    localparam logic       DIR_INGRESS    = 1'b0;

    typedef enum logic [2:0] {
        STAT_NOT_IPV4  = 3'd0,
        STAT_TRUNCATED = 3'd1,
        STAT_LOOPBACK  = 3'd2,
        STAT_UPDATED   = 3'd3,
        STAT_INSERTED  = 3'd4,
        STAT_EVICTED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_UPDATE,
        ST_SKIP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] bytes;
        logic [COUNT_W-1:0] packets;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic compare;
    } scan_ctl_t;

endpackage

@@ rtl/core/fct_entry_mem.sv @@
`timescale 1ns / 1ps

module fct_entry_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output fct_pkg::entry_t  rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  fct_pkg::entry_t  wr_data
);
    import fct_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/fct_scan.sv @@
`timescale 1ns / 1ps

module fct_scan #(
    parameter int IW = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fct_pkg::scan_ctl_t        ctl,
    input  logic [IW-1:0]             cmp_idx,
    input  logic [fct_pkg::KEY_W-1:0] key,
    input  fct_pkg::entry_t           entry,
    output logic                      hit,
    output logic [IW-1:0]             hit_idx,
    output logic [IW-1:0]             min_idx
);
    import fct_pkg::*;

    logic               hit_reg, hit_next;
    logic               first_reg, first_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    logic [IW-1:0]      min_idx_reg, min_idx_next;
    logic [STAMP_W-1:0] min_stamp_reg, min_stamp_next;
    logic               match;
    logic               older;

    // one key compare and one stamp compare per entry read
    always_comb
    begin
        match          = (entry.key == key);
        older          = first_reg || (entry.stamp < min_stamp_reg);
        hit_next       = hit_reg;
        first_next     = first_reg;
        hit_idx_next   = hit_idx_reg;
        min_idx_next   = min_idx_reg;
        min_stamp_next = min_stamp_reg;
        if (ctl.clear)
        begin
            hit_next   = 1'b0;
            first_next = 1'b1;
        end
        else if (ctl.compare)
        begin
            if (match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx;
            end
            if (older)
            begin
                first_next     = 1'b0;
                min_idx_next   = cmp_idx;
                min_stamp_next = entry.stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else
        begin
            hit_reg   <= hit_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        min_idx_reg   <= min_idx_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign hit     = hit_reg;
    assign hit_idx = hit_idx_reg;
    assign min_idx = min_idx_reg;

endmodule

@@ rtl/core/ipv4_flow_counter_lru_table.sv @@
`timescale 1ns / 1ps

// Per-flow IPv4 packet and byte counter. Each accepted word is one packet event; the flow key is
// the direction plus the remote address (destination for egress, source for ingress). Non-IPv4,
// truncated and 127.0.0.0/8 packets are reported with no table access. Otherwise the table is
// searched one stored entry per cycle through the single read port of the entry memory, then the
// matching entry is updated or a new one is written, into the next free slot or over the least
// recently used entry, which is reported. A skipped packet goes from idle to a skip state and back;
// a table packet passes through scan (one read per entry in use), drain, fetch and update, with scan
// and drain left out on an empty table. Skip and update wait while an untaken result still holds the
// output register. Slots fill in index order and are never freed, so a fill count stands in for
// valid bits and no clearing pass follows reset. LRU order is kept by a 64-bit use stamp per entry.
// The result sits in an output register, so the next word can be accepted before it is taken.
module ipv4_flow_counter_lru_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        is_ipv4,
    input  logic        header_complete,
    input  logic        direction,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [15:0] packet_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] remote_address,
    output logic        flow_direction,
    output logic [63:0] total_bytes,
    output logic [63:0] total_packets,
    output logic [31:0] evicted_address,
    output logic        evicted_direction,
    output logic [63:0] evicted_bytes,
    output logic [63:0] evicted_packets
);
    import fct_pkg::*;

    localparam int             IW         = $clog2(TABLE_ENTRIES);
    localparam int             CW         = IW + 1;
    localparam logic [CW-1:0]  FULL_COUNT = CW'(TABLE_ENTRIES);

    state_t              state_reg, state_next;
    logic [IW-1:0]       scan_idx_reg, scan_idx_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]       slot_reg, slot_next;
    status_t             mode_reg, mode_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;

    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [COUNT_W-1:0]  total_bytes_reg, total_bytes_next;
    logic [COUNT_W-1:0]  total_packets_reg, total_packets_next;
    logic [KEY_W-1:0]    ev_key_reg, ev_key_next;
    logic [COUNT_W-1:0]  ev_bytes_reg, ev_bytes_next;
    logic [COUNT_W-1:0]  ev_packets_reg, ev_packets_next;

    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    entry_t              rd_data;
    logic                wr_en;
    entry_t              wr_data;
    scan_ctl_t           scan_ctl;
    logic                hit;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       min_idx;

    logic [ADDR_W-1:0]   sel_remote;
    status_t             item_code;
    logic                item_skip;
    logic                out_free;
    logic                out_load;
    logic [COUNT_W-1:0]  new_bytes;
    logic [COUNT_W-1:0]  new_packets;
    logic [IW-1:0]       slot_pick;

    fct_entry_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data)
    );

    fct_scan #(
        .IW (IW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .cmp_idx (cmp_idx_reg),
        .key     (key_reg),
        .entry   (rd_data),
        .hit     (hit),
        .hit_idx (hit_idx),
        .min_idx (min_idx)
    );

    // packet classification
    always_comb
    begin
        sel_remote = (direction == DIR_EGRESS) ? dest_address : source_address;
        if (!is_ipv4)
        begin
            item_code = STAT_NOT_IPV4;
        end
        else if (!header_complete)
        begin
            item_code = STAT_TRUNCATED;
        end
        else if (sel_remote[31:24] == LOOPBACK_OCTET)
        begin
            item_code = STAT_LOOPBACK;
        end
        else
        begin
            item_code = STAT_UPDATED;
        end
        item_skip = (item_code != STAT_UPDATED);
    end

    always_comb
    begin
        if (mode_reg == STAT_UPDATED)
        begin
            new_bytes   = rd_data.bytes + COUNT_W'(len_reg);
            new_packets = rd_data.packets + COUNT_W'(1);
        end
        else
        begin
            new_bytes   = COUNT_W'(len_reg);
            new_packets = COUNT_W'(1);
        end
        wr_data = '{key: key_reg, bytes: new_bytes, packets: new_packets, stamp: stamp_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        fill_next      = fill_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = scan_idx_reg;
        slot_next      = slot_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        stamp_next     = stamp_reg;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        out_free       = !out_valid_reg || out_ready;
        scan_ctl.clear   = 1'b0;
        scan_ctl.compare = cmp_valid_reg;
        slot_pick      = min_idx;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    scan_ctl.clear = 1'b1;
                    mode_next      = item_code;
                    len_next       = packet_length;
                    scan_idx_next  = '0;
                    if (item_code == STAT_NOT_IPV4 || item_code == STAT_TRUNCATED)
                    begin
                        key_next = '0;
                    end
                    else
                    begin
                        key_next = {direction, sel_remote};
                    end
                    if (item_skip)
                    begin
                        state_next = ST_SKIP;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en          = 1'b1;
                cmp_valid_next = 1'b1;
                if (CW'(scan_idx_reg) + CW'(1) == fill_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (hit)
                begin
                    slot_pick = hit_idx;
                    mode_next = STAT_UPDATED;
                end
                else if (fill_reg != FULL_COUNT)
                begin
                    slot_pick = fill_reg[IW-1:0];
                    mode_next = STAT_INSERTED;
                end
                else
                begin
                    slot_pick = min_idx;
                    mode_next = STAT_EVICTED;
                end
                rd_en      = 1'b1;
                rd_addr    = slot_pick;
                slot_next  = slot_pick;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    out_load   = 1'b1;
                    stamp_next = stamp_reg + STAMP_W'(1);
                    if (mode_reg == STAT_INSERTED)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SKIP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        status_next        = status_reg;
        out_key_next       = out_key_reg;
        total_bytes_next   = total_bytes_reg;
        total_packets_next = total_packets_reg;
        ev_key_next        = ev_key_reg;
        ev_bytes_next      = ev_bytes_reg;
        ev_packets_next    = ev_packets_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = mode_reg;
            out_key_next   = key_reg;
            if (state_reg == ST_UPDATE)
            begin
                total_bytes_next   = new_bytes;
                total_packets_next = new_packets;
            end
            else
            begin
                total_bytes_next   = '0;
                total_packets_next = '0;
            end
            if (state_reg == ST_UPDATE && mode_reg == STAT_EVICTED)
            begin
                ev_key_next     = rd_data.key;
                ev_bytes_next   = rd_data.bytes;
                ev_packets_next = rd_data.packets;
            end
            else
            begin
                ev_key_next     = '0;
                ev_bytes_next   = '0;
                ev_packets_next = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            stamp_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            stamp_reg     <= stamp_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg      <= scan_idx_next;
        cmp_idx_reg       <= cmp_idx_next;
        slot_reg          <= slot_next;
        mode_reg          <= mode_next;
        key_reg           <= key_next;
        len_reg           <= len_next;
        status_reg        <= status_next;
        out_key_reg       <= out_key_next;
        total_bytes_reg   <= total_bytes_next;
        total_packets_reg <= total_packets_next;
        ev_key_reg        <= ev_key_next;
        ev_bytes_reg      <= ev_bytes_next;
        ev_packets_reg    <= ev_packets_next;
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign remote_address    = out_key_reg[ADDR_W-1:0];
    assign flow_direction    = out_key_reg[ADDR_W];
    assign total_bytes       = total_bytes_reg;
    assign total_packets     = total_packets_reg;
    assign evicted_address   = ev_key_reg[ADDR_W-1:0];
    assign evicted_direction = ev_key_reg[ADDR_W];
    assign evicted_bytes     = ev_bytes_reg;
    assign evicted_packets   = ev_packets_reg;

endmodule

@@ rtl/core/fct_checker.sv @@
`timescale 1ns / 1ps

module fct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] remote_address,
    input logic        flow_direction,
    input logic [63:0] total_bytes,
    input logic [63:0] total_packets,
    input logic [31:0] evicted_address,
    input logic        evicted_direction,
    input logic [63:0] evicted_bytes,
    input logic [63:0] evicted_packets
);
    import fct_pkg::*;

    // one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again right after accept");

    // skipped before key selection
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_NOT_IPV4 || status == STAT_TRUNCATED)) |->
        (remote_address == '0 && !flow_direction && total_bytes == '0 && total_packets == '0))
        else $error("skipped word carries key or counts");

    // new flow starts at one packet
    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_INSERTED || status == STAT_EVICTED)) |->
        (total_packets == 64'd1 && total_bytes[63:16] == '0))
        else $error("inserted flow with wrong counts");

    // eviction fields only with eviction
    a_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_EVICTED) |->
        (evicted_address == '0 && !evicted_direction && evicted_bytes == '0 &&
         evicted_packets == '0))
        else $error("eviction fields set without eviction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(total_bytes)))
        else $error("stalled result changed");

endmodule

bind ipv4_flow_counter_lru_table fct_checker u_fct_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .remote_address    (remote_address),
    .flow_direction    (flow_direction),
    .total_bytes       (total_bytes),
    .total_packets     (total_packets),
    .evicted_address   (evicted_address),
    .evicted_direction (evicted_direction),
    .evicted_bytes     (evicted_bytes),
    .evicted_packets   (evicted_packets)
);
